[design/fnvlp_pkg.sv]
package fnvlp_pkg;

  // FNV-1a, 32-bit
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  // key is six bytes, one hash round per byte
  localparam int unsigned KEY_W       = 48;
  localparam int unsigned HASH_ROUNDS = 6;

  // smallest table in use is 16 buckets
  localparam logic [4:0] MIN_LOG2 = 5'd4;

  // request kinds
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_FIND   = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // result status codes
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_CLEARED   = 3'd5;

  // one bucket of the table
  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [15:0]       index;
  } entry_t;

endpackage

[design/fnvlp_hash.sv]
// Iterative FNV-1a over the six key bytes, low byte first.
// One xor-and-multiply round per cycle; done_o pulses once the hash is ready.
module fnvlp_hash (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [fnvlp_pkg::KEY_W-1:0] key_i,
  output logic [31:0]                 hash_o,
  output logic                        done_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] h_q, h_d;
  logic [7:0]  cur_byte;
  logic [31:0] round_val;

  // byte for the current round
  assign cur_byte  = 8'(key_i >> {cnt_q, 3'b000});
  assign round_val = (h_q ^ {24'd0, cur_byte}) * fnvlp_pkg::FNV_PRIME;

  // round sequencing
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    h_d    = h_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 3'd0;
      h_d    = fnvlp_pkg::FNV_BASIS;
    end else if (busy_q) begin
      h_d   = round_val;
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'(fnvlp_pkg::HASH_ROUNDS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // running hash, no reset needed
  always_ff @(posedge clk_i) begin
    h_q <= h_d;
  end

  assign hash_o = h_q;
  assign done_o = done_q;

endmodule

[design/fnv_linear_probe_point_table.sv]
// Hash table of 3D points keyed by three signed 16-bit coordinates, with
// open addressing and linear probing over 2^size_log2 buckets (clamped to
// 16 .. largest power of two not above TABLE_DEPTH). An insert or find first
// hashes the key in the shared FNV-1a round unit, then does one read and one
// compare step per probe on the bucket memory, which has one write and one
// registered read port. A clear sweeps the whole bucket memory of 2^AW
// buckets one entry a cycle; the same sweep runs after reset. No request
// is taken during a sweep (config writes are always taken). One request is
// worked on at a time; its result sits in an output register so the next
// request can be accepted while the result waits.
module fnv_linear_probe_point_table #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,   // size_log2
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // coord_x, coord_y, coord_z, entry_index
  input  logic [1:0]  s_axis_tuser,  // action
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // match_index
  output logic [2:0]  m_axis_tuser   // status
);

  // address width: largest power of two not above the depth
  localparam int unsigned AW    = $clog2(TABLE_DEPTH + 1) - 1;
  localparam int unsigned NBKT  = 1 << AW;
  localparam logic [4:0]  AW_L2 = 5'(AW);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_HASH  = 6'b000010,
    S_READ  = 6'b000100,
    S_CHECK = 6'b001000,
    S_CLEAR = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic              init_q, init_d;
  logic [3:0]        size_q;
  logic [AW-1:0]     clr_cnt_q, clr_cnt_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [AW-1:0]     probe_q, probe_d;
  logic [1:0]        act_q;
  logic [47:0]       key_q;
  logic [15:0]       idx_q;
  logic [2:0]        res_status_q, res_status_d;
  logic [15:0]       res_index_q, res_index_d;
  logic              out_valid_q, out_valid_d;
  logic [2:0]        out_status_q;
  logic [15:0]       out_index_q;
  logic              out_load;

  logic              req_accept;
  logic              hash_start;
  logic [31:0]       hash_val;
  logic              hash_done;

  logic [4:0]        eff_log2;
  logic [AW:0]       bkt_count;
  logic [AW-1:0]     mask;

  fnvlp_pkg::entry_t mem_q [NBKT];
  fnvlp_pkg::entry_t rd_q;
  fnvlp_pkg::entry_t mem_wdata;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;

  // buckets in use, clamped
  always_comb begin
    if ({1'b0, size_q} < fnvlp_pkg::MIN_LOG2) begin
      eff_log2 = fnvlp_pkg::MIN_LOG2;
    end else if ({1'b0, size_q} > AW_L2) begin
      eff_log2 = AW_L2;
    end else begin
      eff_log2 = {1'b0, size_q};
    end
  end

  assign bkt_count = (AW + 1)'(1) << eff_log2;
  assign mask      = bkt_count[AW-1:0] - AW'(1);

  assign s_axis_tready = (state_q == S_IDLE);
  assign req_accept    = s_axis_tvalid && s_axis_tready;
  assign hash_start    = req_accept && (s_axis_tuser != fnvlp_pkg::ACT_CLEAR);

  fnvlp_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (key_q),
    .hash_o  (hash_val),
    .done_o  (hash_done)
  );

  // sequencer
  always_comb begin
    state_d      = state_q;
    init_d       = init_q;
    clr_cnt_d    = clr_cnt_q;
    pos_d        = pos_q;
    probe_d      = probe_q;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    mem_we       = 1'b0;
    mem_waddr    = pos_q;
    mem_wdata    = '{valid: 1'b1, key: key_q, index: idx_q};
    out_load     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_accept) begin
          if (s_axis_tuser == fnvlp_pkg::ACT_CLEAR) begin
            clr_cnt_d = '0;
            state_d   = S_CLEAR;
          end else begin
            state_d = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          pos_d   = hash_val[AW-1:0] & mask;
          probe_d = '0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!rd_q.valid) begin
          // empty bucket ends the search
          res_index_d = 16'd0;
          if (act_q == fnvlp_pkg::ACT_INSERT) begin
            mem_we       = 1'b1;
            res_status_d = fnvlp_pkg::ST_INSERTED;
          end else begin
            res_status_d = fnvlp_pkg::ST_NOT_FOUND;
          end
          state_d = S_DONE;
        end else if (rd_q.key == key_q) begin
          res_index_d  = rd_q.index;
          res_status_d = (act_q == fnvlp_pkg::ACT_INSERT) ? fnvlp_pkg::ST_DUPLICATE
                                                          : fnvlp_pkg::ST_FOUND;
          state_d      = S_DONE;
        end else if (probe_q == mask) begin
          // every bucket in use probed
          res_index_d  = 16'd0;
          res_status_d = fnvlp_pkg::ST_FULL;
          state_d      = S_DONE;
        end else begin
          pos_d   = (pos_q + AW'(1)) & mask;
          probe_d = probe_q + AW'(1);
          state_d = S_READ;
        end
      end
      S_CLEAR: begin
        mem_we          = 1'b1;
        mem_waddr       = clr_cnt_q;
        mem_wdata.valid = 1'b0;
        clr_cnt_d       = clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(NBKT - 1)) begin
          if (init_q) begin
            init_d  = 1'b0;
            state_d = S_IDLE;
          end else begin
            res_status_d = fnvlp_pkg::ST_CLEARED;
            res_index_d  = 16'd0;
            state_d      = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register
  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      init_q      <= 1'b1;
      clr_cnt_q   <= '0;
      size_q      <= 4'd12;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    probe_q      <= probe_d;
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
    if (req_accept) begin
      act_q <= s_axis_tuser;
      key_q <= s_axis_tdata[47:0];
      idx_q <= s_axis_tdata[63:48];
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_index_q  <= res_index_q;
    end
  end

  // bucket memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (state_q == S_READ) begin
      rd_q <= mem_q[pos_q];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_index_q;
  assign m_axis_tuser  = out_status_q;

endmodule
